// ===== rtl/core/bcc_pkg.sv =====
// Shared types, widths and helpers for the barycentric coordinate block.
// Used by the front, back and top modules under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package bcc_pkg;

	localparam int CoordW     = 16;  // input coordinate
	localparam int EdgeW      = 17;  // corner difference
	localparam int ProdW      = 34;  // product of two differences
	localparam int DotW       = 36;  // dot product or 2D cross product
	localparam int HalfW      = 17;  // half of a dot product magnitude
	localparam int MagW       = 2 * HalfW;
	localparam int PartW      = 2 * HalfW;
	localparam int PMagW      = 2 * MagW;
	localparam int WideW      = 72;  // denominator and numerators
	localparam int RoundShift = 17;  // Q16 scaling plus one bit for rounding
	localparam int NumW       = 88;  // dividend, also quotient width
	localparam int DivW       = 70;  // divisor, twice the denominator magnitude
	localparam int QuoW       = 90;  // signed quotient
	localparam int SumW       = 92;  // signed weight before saturation
	localparam int WeightW    = 24;
	localparam int CfgIdxW    = 1;
	localparam int CfgDataW   = 32;
	localparam int ThrW       = 32;
	localparam int MidDepth   = 2;
	localparam int OutDepth   = 2;

	localparam logic signed [SumW-1:0] QOne = SumW'(65536);

	typedef enum logic [CfgIdxW-1:0] {
		REG_PLANAR_MODE = 1'b0,
		REG_DEG_THRESH  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic            planar;
		logic [ThrW-1:0] thr;
	} cfg_t;

	typedef struct packed {
		logic signed [CoordW-1:0] corner_a_x;
		logic signed [CoordW-1:0] corner_a_y;
		logic signed [CoordW-1:0] corner_a_z;
		logic signed [CoordW-1:0] corner_b_x;
		logic signed [CoordW-1:0] corner_b_y;
		logic signed [CoordW-1:0] corner_b_z;
		logic signed [CoordW-1:0] corner_c_x;
		logic signed [CoordW-1:0] corner_c_y;
		logic signed [CoordW-1:0] corner_c_z;
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic signed [CoordW-1:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic            degen;
		logic            neg_v;
		logic            neg_w;
		logic [NumW-1:0] num_v;
		logic [NumW-1:0] num_w;
		logic [DivW-1:0] dvs;
	} front_item_t;

	typedef struct packed {
		logic signed [WeightW-1:0] weight_u;
		logic signed [WeightW-1:0] weight_v;
		logic signed [WeightW-1:0] weight_w;
		logic                      status;
	} out_item_t;

	// Clamp a wide signed weight to the signed Q8.16 output range.
	function automatic logic signed [WeightW-1:0] sat_weight(input logic signed [SumW-1:0] x);
		logic signed [WeightW-1:0] r;
		if (x[SumW-1:WeightW-1] == '0 || x[SumW-1:WeightW-1] == '1) begin
			r = x[WeightW-1:0];
		end else if (x[SumW-1]) begin
			r = {1'b1, {(WeightW-1){1'b0}}};
		end else begin
			r = {1'b0, {(WeightW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/bcc_fifo.sv =====
// Small register queue used between the pipeline halves and at the result side.
// Depends on nothing; a push is taken while full if a pop happens in the same cycle.
`timescale 1ns / 1ps

module bcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             can_push,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign empty    = (count_q == '0);
	assign do_pop   = pop && !empty;
	assign can_push = (count_q < CntW'(DEPTH)) || do_pop;
	assign do_push  = push && can_push;
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/bcc_front.sv =====
// Front half: corner differences, dot or cross products, denominator and
// numerators, degenerate check and dividend setup. Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcc_pkg::cfg_t        cfg,
	input  bcc_pkg::in_item_t    in_item,
	input  logic                 take,
	output logic                 ready,
	output bcc_pkg::front_item_t item,
	output logic                 item_valid,
	input  logic                 item_ready
);
	import bcc_pkg::*;

	logic [6:0] vld_s;
	logic       adv;

	logic signed [CoordW-1:0] ca [3], cb [3], cc [3], cp [3];

	logic signed [EdgeW-1:0] e0_s1 [3], e1_s1 [3], e2_s1 [3];
	logic signed [ProdW-1:0] p00_s2 [3], p01_s2 [3], p11_s2 [3], p20_s2 [3], p21_s2 [3];
	logic signed [ProdW-1:0] pl_s2 [6];
	logic signed [DotW-1:0]  d00_s3, d01_s3, d11_s3, d20_s3, d21_s3;
	logic signed [DotW-1:0]  pden_s3, pnv_s3, pnw_s3;
	logic signed [DotW-1:0]  opa [6], opb [6];
	logic [MagW-1:0]         ma [6], mb [6];
	logic [PartW-1:0]        pll_s4 [6], plh_s4 [6], phl_s4 [6], phh_s4 [6];
	logic [5:0]              sgn_s4, sgn_s5;
	logic signed [DotW-1:0]  pden_s4, pnv_s4, pnw_s4;
	logic [PMagW-1:0]        mag_s5 [6];
	logic signed [DotW-1:0]  pden_s5, pnv_s5, pnw_s5;
	logic signed [WideW-1:0] sv [6];
	logic signed [WideW-1:0] den_s6, nv_s6, nw_s6;
	logic [WideW-1:0]        ad, anv, anw;
	front_item_t             item_s7;

	assign adv        = !vld_s[6] || item_ready;
	assign ready      = adv;
	assign item       = item_s7;
	assign item_valid = vld_s[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[5:0], take};
		end
	end

	assign ca[0] = in_item.corner_a_x;
	assign ca[1] = in_item.corner_a_y;
	assign ca[2] = in_item.corner_a_z;
	assign cb[0] = in_item.corner_b_x;
	assign cb[1] = in_item.corner_b_y;
	assign cb[2] = in_item.corner_b_z;
	assign cc[0] = in_item.corner_c_x;
	assign cc[1] = in_item.corner_c_y;
	assign cc[2] = in_item.corner_c_z;
	assign cp[0] = in_item.point_x;
	assign cp[1] = in_item.point_y;
	assign cp[2] = in_item.point_z;

	// Stage 1: edges relative to corner a.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				e0_s1[k] <= EdgeW'(cb[k]) - EdgeW'(ca[k]);
				e1_s1[k] <= EdgeW'(cc[k]) - EdgeW'(ca[k]);
				e2_s1[k] <= EdgeW'(cp[k]) - EdgeW'(ca[k]);
			end
		end
	end

	// Stage 2: all products for both forms.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				p00_s2[k] <= e0_s1[k] * e0_s1[k];
				p01_s2[k] <= e0_s1[k] * e1_s1[k];
				p11_s2[k] <= e1_s1[k] * e1_s1[k];
				p20_s2[k] <= e2_s1[k] * e0_s1[k];
				p21_s2[k] <= e2_s1[k] * e1_s1[k];
			end
			pl_s2[0] <= e0_s1[0] * e1_s1[1];
			pl_s2[1] <= e1_s1[0] * e0_s1[1];
			pl_s2[2] <= e2_s1[0] * e1_s1[1];
			pl_s2[3] <= e1_s1[0] * e2_s1[1];
			pl_s2[4] <= e0_s1[0] * e2_s1[1];
			pl_s2[5] <= e2_s1[0] * e0_s1[1];
		end
	end

	// Stage 3: dot products and planar cross products.
	always_ff @(posedge clk) begin
		if (adv) begin
			d00_s3  <= DotW'(p00_s2[0]) + DotW'(p00_s2[1]) + DotW'(p00_s2[2]);
			d01_s3  <= DotW'(p01_s2[0]) + DotW'(p01_s2[1]) + DotW'(p01_s2[2]);
			d11_s3  <= DotW'(p11_s2[0]) + DotW'(p11_s2[1]) + DotW'(p11_s2[2]);
			d20_s3  <= DotW'(p20_s2[0]) + DotW'(p20_s2[1]) + DotW'(p20_s2[2]);
			d21_s3  <= DotW'(p21_s2[0]) + DotW'(p21_s2[1]) + DotW'(p21_s2[2]);
			pden_s3 <= DotW'(pl_s2[0]) - DotW'(pl_s2[1]);
			pnv_s3  <= DotW'(pl_s2[2]) - DotW'(pl_s2[3]);
			pnw_s3  <= DotW'(pl_s2[4]) - DotW'(pl_s2[5]);
		end
	end

	// Stage 4: Gram products split into four half-width partial products each.
	assign opa[0] = d00_s3;
	assign opb[0] = d11_s3;
	assign opa[1] = d01_s3;
	assign opb[1] = d01_s3;
	assign opa[2] = d11_s3;
	assign opb[2] = d20_s3;
	assign opa[3] = d01_s3;
	assign opb[3] = d21_s3;
	assign opa[4] = d00_s3;
	assign opb[4] = d21_s3;
	assign opa[5] = d01_s3;
	assign opb[5] = d20_s3;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			ma[j] = opa[j][DotW-1] ? MagW'(-opa[j]) : MagW'(opa[j]);
			mb[j] = opb[j][DotW-1] ? MagW'(-opb[j]) : MagW'(opb[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 6; j++) begin
				pll_s4[j] <= PartW'(ma[j][HalfW-1:0]) * PartW'(mb[j][HalfW-1:0]);
				plh_s4[j] <= PartW'(ma[j][HalfW-1:0]) * PartW'(mb[j][MagW-1:HalfW]);
				phl_s4[j] <= PartW'(ma[j][MagW-1:HalfW]) * PartW'(mb[j][HalfW-1:0]);
				phh_s4[j] <= PartW'(ma[j][MagW-1:HalfW]) * PartW'(mb[j][MagW-1:HalfW]);
				sgn_s4[j] <= opa[j][DotW-1] ^ opb[j][DotW-1];
			end
			pden_s4 <= pden_s3;
			pnv_s4  <= pnv_s3;
			pnw_s4  <= pnw_s3;
		end
	end

	// Stage 5: recombine the partial products into full magnitudes.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 6; j++) begin
				mag_s5[j] <= (PMagW'(phh_s4[j]) << MagW) + (PMagW'(plh_s4[j]) << HalfW)
					+ (PMagW'(phl_s4[j]) << HalfW) + PMagW'(pll_s4[j]);
			end
			sgn_s5  <= sgn_s4;
			pden_s5 <= pden_s4;
			pnv_s5  <= pnv_s4;
			pnw_s5  <= pnw_s4;
		end
	end

	// Stage 6: signed differences, or the planar values in planar mode.
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			sv[j] = WideW'(mag_s5[j]);
			if (sgn_s5[j]) begin
				sv[j] = -sv[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cfg.planar) begin
				den_s6 <= WideW'(pden_s5);
				nv_s6  <= WideW'(pnv_s5);
				nw_s6  <= WideW'(pnw_s5);
			end else begin
				den_s6 <= sv[0] - sv[1];
				nv_s6  <= sv[2] - sv[3];
				nw_s6  <= sv[4] - sv[5];
			end
		end
	end

	// Stage 7: classify and set up round-to-nearest division by two |den|.
	always_comb begin
		ad  = den_s6[WideW-1] ? WideW'(-den_s6) : WideW'(den_s6);
		anv = nv_s6[WideW-1] ? WideW'(-nv_s6) : WideW'(nv_s6);
		anw = nw_s6[WideW-1] ? WideW'(-nw_s6) : WideW'(nw_s6);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s7.degen <= (ad[WideW-1:ThrW] == '0) && (ad[ThrW-1:0] <= cfg.thr);
			item_s7.neg_v <= nv_s6[WideW-1] ^ den_s6[WideW-1];
			item_s7.neg_w <= nw_s6[WideW-1] ^ den_s6[WideW-1];
			item_s7.num_v <= (NumW'(anv) << RoundShift) + NumW'(ad);
			item_s7.num_w <= (NumW'(anw) << RoundShift) + NumW'(ad);
			item_s7.dvs   <= {ad[DivW-2:0], 1'b0};
		end
	end

endmodule

// ===== rtl/core/bcc_back.sv =====
// Back half: two pipelined restoring dividers, one quotient bit per stage,
// then sign, u = 1 - v - w and saturation. Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcc_pkg::front_item_t item,
	input  logic                 item_avail,
	output logic                 item_take,
	output bcc_pkg::out_item_t   res,
	output logic                 res_valid,
	input  logic                 res_ready
);
	import bcc_pkg::*;

	logic            adv;
	logic [NumW:0]   vld_s;
	logic [DivW-1:0] rem_v_s [NumW+1], rem_w_s [NumW+1], dvs_s [NumW+1];
	logic [NumW-1:0] nq_v_s [NumW+1], nq_w_s [NumW+1];
	logic [2:0]      meta_s [NumW+1];  // degen, neg_v, neg_w

	logic                   vld_pa, vld_pb;
	logic                   degen_pa;
	logic signed [QuoW-1:0] v_pa, w_pa;
	logic signed [SumW-1:0] u_sum;
	out_item_t              res_pb;

	assign adv       = !vld_pb || res_ready;
	assign item_take = adv && item_avail;
	assign res       = res_pb;
	assign res_valid = vld_pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vld_pa <= 1'b0;
			vld_pb <= 1'b0;
		end else if (adv) begin
			vld_s  <= {vld_s[NumW-1:0], item_avail};
			vld_pa <= vld_s[NumW];
			vld_pb <= vld_pa;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_v_s[0] <= '0;
			rem_w_s[0] <= '0;
			nq_v_s[0]  <= item.num_v;
			nq_w_s[0]  <= item.num_w;
			dvs_s[0]   <= item.dvs;
			meta_s[0]  <= {item.degen, item.neg_v, item.neg_w};
		end
	end

	// The dividend shifts out of the top of nq while quotient bits fill the bottom.
	for (genvar k = 0; k < NumW; k++) begin : g_div
		logic [DivW:0] tv, tw;
		logic          gev, gew;

		always_comb begin
			tv  = {rem_v_s[k], nq_v_s[k][NumW-1]};
			tw  = {rem_w_s[k], nq_w_s[k][NumW-1]};
			gev = tv >= {1'b0, dvs_s[k]};
			gew = tw >= {1'b0, dvs_s[k]};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_v_s[k+1] <= gev ? DivW'(tv - {1'b0, dvs_s[k]}) : tv[DivW-1:0];
				rem_w_s[k+1] <= gew ? DivW'(tw - {1'b0, dvs_s[k]}) : tw[DivW-1:0];
				nq_v_s[k+1]  <= {nq_v_s[k][NumW-2:0], gev};
				nq_w_s[k+1]  <= {nq_w_s[k][NumW-2:0], gew};
				dvs_s[k+1]   <= dvs_s[k];
				meta_s[k+1]  <= meta_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_pa <= meta_s[NumW][2];
			v_pa     <= meta_s[NumW][1] ? -QuoW'(nq_v_s[NumW]) : QuoW'(nq_v_s[NumW]);
			w_pa     <= meta_s[NumW][0] ? -QuoW'(nq_w_s[NumW]) : QuoW'(nq_w_s[NumW]);
		end
	end

	assign u_sum = QOne - SumW'(v_pa) - SumW'(w_pa);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (degen_pa) begin
				res_pb.weight_u <= '0;
				res_pb.weight_v <= '0;
				res_pb.weight_w <= '0;
				res_pb.status   <= 1'b1;
			end else begin
				res_pb.weight_u <= sat_weight(u_sum);
				res_pb.weight_v <= sat_weight(SumW'(v_pa));
				res_pb.weight_w <= sat_weight(SumW'(w_pa));
				res_pb.status   <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/triangle_barycentric_coords_top.sv =====
// Top level of the barycentric coordinate block: configuration registers,
// front and back pipelines and the queues between them. Depends on bcc_pkg.
//
//   Channel   Handshake               Payload
//   input     push / full             corner_a_*, corner_b_*, corner_c_*, point_*
//   result    pop / empty             weight_u, weight_v, weight_w, status
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is accepted per cycle while full is low; its result passes the front
// stages, the middle queue and the 88 stages of the quotient-bit pipeline.
// Reset clears the configuration registers, the queues and all valid bits;
// the block is ready in the first cycle after reset. When results are not
// popped, the back pipeline holds, then the middle queue fills, then full rises.
`timescale 1ns / 1ps

module triangle_barycentric_coords_top #(
	parameter int MID_DEPTH = bcc_pkg::MidDepth,
	parameter int OUT_DEPTH = bcc_pkg::OutDepth
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_a_x,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_a_y,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_a_z,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_b_x,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_b_y,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_b_z,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_c_x,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_c_y,
	input  logic signed [bcc_pkg::CoordW-1:0]     corner_c_z,
	input  logic signed [bcc_pkg::CoordW-1:0]     point_x,
	input  logic signed [bcc_pkg::CoordW-1:0]     point_y,
	input  logic signed [bcc_pkg::CoordW-1:0]     point_z,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [bcc_pkg::WeightW-1:0]    weight_u,
	output logic signed [bcc_pkg::WeightW-1:0]    weight_v,
	output logic signed [bcc_pkg::WeightW-1:0]    weight_w,
	output logic                                  status,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bcc_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [bcc_pkg::CfgDataW-1:0]          cfg_data
);
	import bcc_pkg::*;

	cfg_t        cfg_q;
	in_item_t    in_item;
	logic        front_ready, front_take;
	front_item_t f_item, b_item;
	logic        f_valid, mid_can_push, mid_empty, b_take;
	out_item_t   b_res, o_res;
	logic        b_valid, out_can_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PLANAR_MODE: cfg_q.planar <= cfg_data[0];
				REG_DEG_THRESH:  cfg_q.thr    <= cfg_data[ThrW-1:0];
				default:         cfg_q        <= cfg_q;
			endcase
		end
	end

	assign in_item.corner_a_x = corner_a_x;
	assign in_item.corner_a_y = corner_a_y;
	assign in_item.corner_a_z = corner_a_z;
	assign in_item.corner_b_x = corner_b_x;
	assign in_item.corner_b_y = corner_b_y;
	assign in_item.corner_b_z = corner_b_z;
	assign in_item.corner_c_x = corner_c_x;
	assign in_item.corner_c_y = corner_c_y;
	assign in_item.corner_c_z = corner_c_z;
	assign in_item.point_x    = point_x;
	assign in_item.point_y    = point_y;
	assign in_item.point_z    = point_z;

	assign full       = !front_ready;
	assign front_take = push && front_ready;

	bcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_item   (in_item),
		.take      (front_take),
		.ready     (front_ready),
		.item      (f_item),
		.item_valid(f_valid),
		.item_ready(mid_can_push)
	);

	bcc_fifo #(
		.WIDTH($bits(front_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_valid),
		.wdata   (f_item),
		.can_push(mid_can_push),
		.pop     (b_take),
		.rdata   (b_item),
		.empty   (mid_empty)
	);

	bcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (b_item),
		.item_avail(!mid_empty),
		.item_take (b_take),
		.res       (b_res),
		.res_valid (b_valid),
		.res_ready (out_can_push)
	);

	bcc_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (b_valid),
		.wdata   (b_res),
		.can_push(out_can_push),
		.pop     (pop),
		.rdata   (o_res),
		.empty   (empty)
	);

	assign weight_u = o_res.weight_u;
	assign weight_v = o_res.weight_v;
	assign weight_w = o_res.weight_w;
	assign status   = o_res.status;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for triangle_barycentric_coords_top: directed and random
// triangles under several mode and threshold settings, checked against an in-bench predictor.
// Depends on bcc_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;
	import bcc_pkg::*;

	typedef logic signed [127:0] wide_t;

	localparam int         ItemsPerPhase = 85;
	localparam int         WatchLimit    = 20000;
	localparam int         DrainCycles   = 150;
	localparam wide_t      QUnit         = 128'sd65536;
	localparam wide_t      WMax          = 128'sd8388607;
	localparam wide_t      WMin          = -128'sd8388608;

	class weight_scoreboard;
		logic            planar;
		logic [ThrW-1:0] thr;
		out_item_t       pending[$];
		int              errors;

		function new();
			planar = 1'b0;
			thr = '0;
			errors = 0;
		endfunction

		function wide_t q16_div(wide_t num, wide_t den);
			wide_t an, ad, q;
			an = num < 0 ? -num : num;
			ad = den < 0 ? -den : den;
			q = ((an <<< 17) + ad) / (ad <<< 1);
			return ((num < 0) != (den < 0)) ? -q : q;
		endfunction

		function logic signed [WeightW-1:0] clamp24(wide_t x);
			if (x > WMax) return WMax[WeightW-1:0];
			if (x < WMin) return WMin[WeightW-1:0];
			return x[WeightW-1:0];
		endfunction

		// Works out the weights of an accepted item and queues them.
		function void note(in_item_t it);
			longint    e0[3], e1[3], e2[3], a[3];
			longint    d00, d01, d11, d20, d21;
			wide_t     den, nv, nw, ad, v, w;
			out_item_t r;
			a[0] = it.corner_a_x; a[1] = it.corner_a_y; a[2] = it.corner_a_z;
			e0[0] = longint'(it.corner_b_x) - a[0];
			e0[1] = longint'(it.corner_b_y) - a[1];
			e0[2] = longint'(it.corner_b_z) - a[2];
			e1[0] = longint'(it.corner_c_x) - a[0];
			e1[1] = longint'(it.corner_c_y) - a[1];
			e1[2] = longint'(it.corner_c_z) - a[2];
			e2[0] = longint'(it.point_x) - a[0];
			e2[1] = longint'(it.point_y) - a[1];
			e2[2] = longint'(it.point_z) - a[2];
			if (planar) begin
				den = wide_t'(e0[0] * e1[1] - e1[0] * e0[1]);
				nv = wide_t'(e2[0] * e1[1] - e1[0] * e2[1]);
				nw = wide_t'(e0[0] * e2[1] - e2[0] * e0[1]);
			end else begin
				d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
				for (int k = 0; k < 3; k++) begin
					d00 += e0[k] * e0[k];
					d01 += e0[k] * e1[k];
					d11 += e1[k] * e1[k];
					d20 += e2[k] * e0[k];
					d21 += e2[k] * e1[k];
				end
				den = wide_t'(d00) * wide_t'(d11) - wide_t'(d01) * wide_t'(d01);
				nv = wide_t'(d11) * wide_t'(d20) - wide_t'(d01) * wide_t'(d21);
				nw = wide_t'(d00) * wide_t'(d21) - wide_t'(d01) * wide_t'(d20);
			end
			ad = den < 0 ? -den : den;
			if (ad <= wide_t'({96'b0, thr})) begin
				r = '{weight_u: '0, weight_v: '0, weight_w: '0, status: 1'b1};
			end else begin
				v = q16_div(nv, den);
				w = q16_div(nw, den);
				r.weight_u = clamp24(QUnit - v - w);
				r.weight_v = clamp24(v);
				r.weight_w = clamp24(w);
				r.status = 1'b0;
			end
			pending.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch on %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		task check(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.weight_u !== want.weight_u) report("weight_u", got.weight_u, want.weight_u);
			if (got.weight_v !== want.weight_v) report("weight_v", got.weight_v, want.weight_v);
			if (got.weight_w !== want.weight_w) report("weight_w", got.weight_w, want.weight_w);
			if (got.status !== want.status) report("status", got.status, want.status);
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                pop = 1'b0;
	logic                full, empty, cfg_ready, status;
	logic                cfg_valid = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic signed [WeightW-1:0] weight_u, weight_v, weight_w;
	in_item_t            stim = '0;
	bit                  calm = 1'b0;
	int                  quiet = 0;
	weight_scoreboard    sb = new();

	always #10 clk = ~clk;

	triangle_barycentric_coords_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.corner_a_x(stim.corner_a_x), .corner_a_y(stim.corner_a_y),
		.corner_a_z(stim.corner_a_z), .corner_b_x(stim.corner_b_x),
		.corner_b_y(stim.corner_b_y), .corner_b_z(stim.corner_b_z),
		.corner_c_x(stim.corner_c_x), .corner_c_y(stim.corner_c_y),
		.corner_c_z(stim.corner_c_z), .point_x(stim.point_x),
		.point_y(stim.point_y), .point_z(stim.point_z),
		.empty(empty), .pop(pop),
		.weight_u(weight_u), .weight_v(weight_v), .weight_w(weight_w), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Monitor and watchdog.
	always @(posedge clk) begin : monitor
		bit seen;
		seen = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				sb.note(stim);
				seen = 1'b1;
			end
			if (pop && !empty) begin
				sb.check('{weight_u: weight_u, weight_v: weight_v, weight_w: weight_w,
					status: status});
				seen = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_reg_t'(cfg_index) == REG_PLANAR_MODE) sb.planar = cfg_data[0];
				else sb.thr = cfg_data;
				seen = 1'b1;
			end
			quiet <= seen ? 0 : quiet + 1;
			if (quiet >= WatchLimit) begin
				$display("timeout with %0d results outstanding", sb.pending.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver side stalls in bursts until the last phase.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 10);
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	// Leaves valid high; the caller drops it after the last write.
	task write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drives one triangle; returns at the edge where it is taken.
	task send_item(in_item_t it);
		if (!calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push <= 1'b1;
		stim <= it;
		do @(posedge clk); while (full);
	endtask

	function automatic logic signed [CoordW-1:0] near(logic signed [CoordW-1:0] c, int span);
		return CoordW'(int'(c) + $urandom_range(0, 2 * span) - span);
	endfunction

	// Mostly compact triangles with the point nearby; the rest full range.
	function automatic in_item_t random_item();
		in_item_t it;
		int       span;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		if ($urandom_range(0, 3) != 0) begin
			span = $urandom_range(0, 2) == 0 ? 8 : 2000;
			it.corner_a_x = CoordW'($urandom_range(0, 40000) - 20000);
			it.corner_a_y = CoordW'($urandom_range(0, 40000) - 20000);
			it.corner_a_z = CoordW'($urandom_range(0, 40000) - 20000);
			it.corner_b_x = near(it.corner_a_x, span);
			it.corner_b_y = near(it.corner_a_y, span);
			it.corner_b_z = near(it.corner_a_z, span);
			it.corner_c_x = near(it.corner_a_x, span);
			it.corner_c_y = near(it.corner_a_y, span);
			it.corner_c_z = near(it.corner_a_z, span);
			it.point_x = near(it.corner_a_x, span);
			it.point_y = near(it.corner_a_y, span);
			it.point_z = near(it.corner_a_z, span);
		end
		return it;
	endfunction

	task directed_items();
		in_item_t it;
		// Right triangle at the origin; the point walks through the corners.
		it = '{0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 0};
		send_item(it);
		it.point_x = 100; send_item(it);
		it.point_x = 0; it.point_y = 100; send_item(it);
		it.point_x = 33; it.point_y = 33; it.point_z = -5; send_item(it);
		// Degenerate: all corners equal, then collinear corners.
		send_item('{7, 7, 7, 7, 7, 7, 7, 7, 7, 1, 2, 3});
		send_item('{0, 0, 0, 1, 1, 1, 2, 2, 2, 5, -5, 0});
		// Tiny triangle, far point: weights saturate both ways.
		send_item('{0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, -32768, 0});
		send_item('{0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, 32767, 32767});
		// Extreme coordinates.
		send_item('{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767,
			32767, 32767, -32768});
		send_item('{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768,
			-32768, -32768, 32767});
		send_item('{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, 0});
		// Rounding: third weights of a small triangle.
		send_item('{0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0});
		send_item('{0, 0, 0, 3, 0, 0, 0, 3, 0, -1, 1, 0});
		// Clockwise winding gives a negative planar denominator.
		send_item('{0, 0, 0, 0, 100, 0, 100, 0, 0, 25, 50, 9});
		// Same corners differing only in z.
		send_item('{5, 5, 0, 5, 5, 900, 5, 5, -900, 5, 5, 1});
	endtask

	initial begin
		logic            modes[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		logic [ThrW-1:0] thrs[6];
		thrs = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1000, 32'hFFFF_FFFF, $urandom_range(0, 50000)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			// Registers change only with nothing in flight.
			wait (sb.pending.size() == 0);
			@(posedge clk);
			write_reg(REG_PLANAR_MODE, {31'b0, modes[ph]});
			write_reg(REG_DEG_THRESH, thrs[ph]);
			cfg_valid <= 1'b0;
			calm = (ph == 5);
			if (ph < 2) directed_items();
			for (int i = 0; i < ItemsPerPhase; i++) send_item(random_item());
			push <= 1'b0;
		end
		wait (sb.pending.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/bcc_pkg.sv
rtl/core/bcc_fifo.sv
rtl/core/bcc_front.sv
rtl/core/bcc_back.sv
rtl/core/triangle_barycentric_coords_top.sv
dv/testbench.sv
